FILE: design/complex_number_alu_unit_assert.svh
// Assertion helpers for the top-level design file.
`ifndef COMPLEX_NUMBER_ALU_UNIT_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CNA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CNA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cna_pkg.sv
package cna_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // dividend magnitude width; fraction bits shift in as zeros after it
  localparam int unsigned MAG_W = 64;

  typedef struct packed {
    logic [63:0]        rem;
    logic [63:0]        num;
    logic [32:0]        q;
    logic               qo;
    logic               neg;
    logic signed [65:0] pre;
  } lane_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        dz;
    logic [63:0] d;
    lane_t       re;
    lane_t       im;
  } item_t;

endpackage

FILE: design/cna_front.sv
module cna_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic               out_vld,
  output cna_pkg::item_t     out_item
);
  import cna_pkg::*;

  logic               v1_r;
  logic [1:0]         cmd1_r;
  logic signed [31:0] ar_r, ai_r, br_r, bi_r;
  logic signed [63:0] prr_r, pii_r, pri_r, pir_r, srr_r, sii_r;

  logic               v2_r;
  item_t              item_r, item_nxt;

  logic signed [32:0] s_re, s_im;
  logic signed [64:0] m_re, m_im, ms_re, ms_im, n_re, n_im, nn_re, nn_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= in_cmd;
      ar_r   <= in_a_re;
      ai_r   <= in_a_im;
      br_r   <= in_b_re;
      bi_r   <= in_b_im;
      prr_r  <= 64'(in_a_re) * 64'(in_b_re);
      pii_r  <= 64'(in_a_im) * 64'(in_b_im);
      pri_r  <= 64'(in_a_re) * 64'(in_b_im);
      pir_r  <= 64'(in_a_im) * 64'(in_b_re);
      srr_r  <= 64'(in_b_re) * 64'(in_b_re);
      sii_r  <= 64'(in_b_im) * 64'(in_b_im);
      item_r <= item_nxt;
    end
  end

  always_comb begin
    item_nxt     = '0;
    item_nxt.cmd = cmd1_r;
    s_re  = 33'sd0;
    s_im  = 33'sd0;
    m_re  = {prr_r[63], prr_r} - {pii_r[63], pii_r};
    m_im  = {pri_r[63], pri_r} + {pir_r[63], pir_r};
    ms_re = m_re >>> FRAC_BITS;
    ms_im = m_im >>> FRAC_BITS;
    n_re  = {prr_r[63], prr_r} + {pii_r[63], pii_r};
    n_im  = {pir_r[63], pir_r} - {pri_r[63], pri_r};
    nn_re = -n_re;
    nn_im = -n_im;
    case (cmd1_r)
      CMD_ADD: begin
        s_re = {ar_r[31], ar_r} + {br_r[31], br_r};
        s_im = {ai_r[31], ai_r} + {bi_r[31], bi_r};
        item_nxt.re.pre = {{33{s_re[32]}}, s_re};
        item_nxt.im.pre = {{33{s_im[32]}}, s_im};
      end
      CMD_SUB: begin
        s_re = {ar_r[31], ar_r} - {br_r[31], br_r};
        s_im = {ai_r[31], ai_r} - {bi_r[31], bi_r};
        item_nxt.re.pre = {{33{s_re[32]}}, s_re};
        item_nxt.im.pre = {{33{s_im[32]}}, s_im};
      end
      CMD_MUL: begin
        item_nxt.re.pre = {ms_re[64], ms_re};
        item_nxt.im.pre = {ms_im[64], ms_im};
      end
      default: begin
        item_nxt.d      = 64'(srr_r) + 64'(sii_r);
        item_nxt.dz     = (item_nxt.d == 64'd0);
        item_nxt.re.neg = n_re[64];
        item_nxt.im.neg = n_im[64];
        item_nxt.re.num = n_re[64] ? nn_re[63:0] : n_re[63:0];
        item_nxt.im.num = n_im[64] ? nn_im[63:0] : n_im[63:0];
      end
    endcase
  end

  assign out_vld  = v2_r;
  assign out_item = item_r;

endmodule

FILE: design/cna_cell.sv
module cna_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  cna_pkg::item_t in_item,
  output logic           out_vld,
  output cna_pkg::item_t out_item
);
  import cna_pkg::*;

  logic  vld_r;
  item_t item_r, item_nxt;

  // one restoring-division step: bring in the next dividend bit
  function automatic lane_t div_step(lane_t l, logic [63:0] d);
    logic [64:0] r2;
    lane_t       s;
    s      = l;
    r2     = {l.rem, l.num[63]};
    s.num  = {l.num[62:0], 1'b0};
    s.qo   = l.qo | l.q[32];
    if (r2 >= {1'b0, d}) begin
      s.rem = 64'(r2 - {1'b0, d});
      s.q   = {l.q[31:0], 1'b1};
    end else begin
      s.rem = r2[63:0];
      s.q   = {l.q[31:0], 1'b0};
    end
    return s;
  endfunction

  always_comb begin
    item_nxt    = in_item;
    item_nxt.re = div_step(in_item.re, in_item.d);
    item_nxt.im = div_step(in_item.im, in_item.d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

FILE: design/complex_number_alu_unit.sv
// channel | dir | tdata (low bit up)                  | tuser
// in_     | in  | a_re[31:0] a_im b_re b_im (128 bits) | cmd[1:0]
// out_    | out | res_re[31:0] res_im (64 bits)        | status[1:0]
// One beat accepted per cycle unless the output stalls. The chain has two front
// stages (products, then sums), 64 + FRAC_BITS division cells, one output stage.
// Every operation travels the full chain, so results leave in input order.
// A stalled output freezes the whole chain; in_tready follows that enable.
// Reset clears the valid bits only.
`include "complex_number_alu_unit_assert.svh"

module complex_number_alu_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_re, a_im, b_re, b_im
  input  logic [1:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // res_re, res_im
  output logic [1:0]   out_tuser   // status
);
  import cna_pkg::*;

  localparam int unsigned NCELL = MAG_W + FRAC_BITS;

  logic        en;
  logic        cv   [0:NCELL];
  item_t       citem[0:NCELL];
  item_t       fin;

  logic        out_tvalid_r;
  logic [63:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]  out_tuser_r, out_tuser_nxt;
  logic [32:0] sre, sim;
  logic        clamped, st_legal;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  cna_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_cmd  (in_tuser),
    .in_a_re (in_tdata[31:0]),
    .in_a_im (in_tdata[63:32]),
    .in_b_re (in_tdata[95:64]),
    .in_b_im (in_tdata[127:96]),
    .out_vld (cv[0]),
    .out_item(citem[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cna_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (cv[i]),
      .in_item (citem[i]),
      .out_vld (cv[i+1]),
      .out_item(citem[i+1])
    );
  end

  function automatic logic [32:0] sat_pre(logic signed [65:0] p);
    if (p > 66'sd2147483647) begin
      return {1'b1, 32'h7FFFFFFF};
    end else if (p < -66'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, p[31:0]};
  endfunction

  function automatic logic [32:0] sat_quo(lane_t l);
    logic [32:0] nq;
    nq = -l.q;
    if (l.neg) begin
      if (l.qo || l.q > 33'h080000000) begin
        return {1'b1, 32'h80000000};
      end
      return {1'b0, nq[31:0]};
    end
    if (l.qo || l.q > 33'h07FFFFFFF) begin
      return {1'b1, 32'h7FFFFFFF};
    end
    return {1'b0, l.q[31:0]};
  endfunction

  assign fin = citem[NCELL];

  always_comb begin
    if (fin.cmd == CMD_DIV) begin
      sre = sat_quo(fin.re);
      sim = sat_quo(fin.im);
    end else begin
      sre = sat_pre(fin.re.pre);
      sim = sat_pre(fin.im.pre);
    end
    out_tdata_nxt = {sim[31:0], sre[31:0]};
    out_tuser_nxt = (sre[32] || sim[32]) ? ST_OVF : ST_OK;
    if (fin.cmd == CMD_DIV && fin.dz) begin
      out_tdata_nxt = 64'd0;
      out_tuser_nxt = ST_DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign clamped  = out_tdata_r[31:0] == 32'h7FFFFFFF || out_tdata_r[31:0] == 32'h80000000 ||
                    out_tdata_r[63:32] == 32'h7FFFFFFF || out_tdata_r[63:32] == 32'h80000000;
  assign st_legal = out_tuser_r == ST_OK || out_tuser_r == ST_DZ || out_tuser_r == ST_OVF;

  `CNA_ASSERT_IMP(a_dz_zero, out_tvalid_r && out_tuser_r == ST_DZ, ~|out_tdata_r, "dz beat nonzero")
  `CNA_ASSERT_IMP(a_status_code, out_tvalid_r, st_legal, "bad status code")
  `CNA_ASSERT_IMP(a_ovf_clamped, out_tvalid_r && out_tuser_r == ST_OVF, clamped, "ovf unclamped")
  `CNA_ASSERT_NXT(a_chain_hold, !en, $stable(cv[NCELL]) && $stable(cv[0]), "chain moved on stall")

endmodule
